>>> design/rgb2hsl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RGB to HSL converter.
// Depends on nothing; used by every module of the block.
package rgb2hsl_pkg;

  // Field widths of the pixel and result requests
  localparam int CH_W   = 8;
  localparam int FRAC_W = 16;
  localparam int SUM_W  = CH_W + 1;

  // Divider widths: 6*d < 2^(CH_W+3), one extra bit for the doubled remainder
  localparam int DIV_W   = CH_W + 4;
  localparam int QUO_W   = FRAC_W + 1;
  localparam int N_CELLS = QUO_W;

  localparam logic [SUM_W-1:0] FULL_SCALE = SUM_W'((1 << CH_W) - 1);
  localparam logic [SUM_W-1:0] TWO_FS     = SUM_W'(2 * ((1 << CH_W) - 1));

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [FRAC_W-1:0] hue;
    logic [FRAC_W-1:0] saturation;
    logic [SUM_W-1:0]  lightness_sum;
  } hsl_t;

  // Work handed from one divider cell to the next
  typedef struct packed {
    logic              grey;
    logic [SUM_W-1:0]  lsum;
    logic [DIV_W-1:0]  sat_rem;
    logic [DIV_W-1:0]  sat_den;
    logic [QUO_W-1:0]  sat_quo;
    logic [DIV_W-1:0]  hue_rem;
    logic [DIV_W-1:0]  hue_den;
    logic [QUO_W-1:0]  hue_quo;
  } div_t;

endpackage

>>> design/rgb2hsl_front.sv
`timescale 1ns / 1ps
// Front stage: channel extremes, lightness sum and divider operands.
// Depends on rgb2hsl_pkg.
module rgb2hsl_front import rgb2hsl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  pix_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output div_t data_o
);

  logic                    valid_q, valid_d;
  div_t                    data_q, data_d;
  logic [CH_W-1:0]         mx, mn, d;
  logic [SUM_W-1:0]        sum, den;
  logic [DIV_W-1:0]        d_w, six_d;
  logic signed [DIV_W-1:0] val, val_adj;

  // Find extremes, difference and sum
  always_comb begin
    mx = data_i.red;
    mn = data_i.red;
    if (data_i.green > mx) mx = data_i.green;
    if (data_i.blue > mx)  mx = data_i.blue;
    if (data_i.green < mn) mn = data_i.green;
    if (data_i.blue < mn)  mn = data_i.blue;
    d     = mx - mn;
    sum   = {1'b0, mx} + {1'b0, mn};
    den   = (sum < FULL_SCALE) ? sum : (TWO_FS - sum);
    d_w   = DIV_W'(d);
    six_d = (d_w << 2) + (d_w << 1);
  end

  // Pick the hue sector; red wins ties, then green
  always_comb begin
    if (data_i.red == mx) begin
      val = $signed(DIV_W'(data_i.green)) - $signed(DIV_W'(data_i.blue));
    end else if (data_i.green == mx) begin
      val = $signed(d_w << 1) + $signed(DIV_W'(data_i.blue))
            - $signed(DIV_W'(data_i.red));
    end else begin
      val = $signed(d_w << 2) + $signed(DIV_W'(data_i.red))
            - $signed(DIV_W'(data_i.green));
    end
    val_adj = (val < 0) ? (val + $signed(six_d)) : val;
  end

  // Build the operand set for the divider chain
  always_comb begin
    data_d.grey    = (d == '0);
    data_d.lsum    = sum;
    data_d.sat_rem = d_w;
    data_d.sat_den = DIV_W'(den);
    data_d.sat_quo = '0;
    data_d.hue_rem = $unsigned(val_adj);
    data_d.hue_den = six_d;
    data_d.hue_quo = '0;
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  // Hold the stage valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load the operands when a request moves in
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> design/rgb2hsl_cell.sv
`timescale 1ns / 1ps
// Divider cell: one restoring quotient bit for saturation and for hue.
// Depends on rgb2hsl_pkg.
module rgb2hsl_cell import rgb2hsl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  div_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output div_t data_o
);

  logic             valid_q, valid_d;
  div_t             data_q, data_d;
  logic             sat_ge, hue_ge;
  logic [DIV_W-1:0] sat_sub, hue_sub;

  // Trial subtract, then double the remainder for the next bit
  always_comb begin
    sat_ge  = (data_i.sat_rem >= data_i.sat_den);
    hue_ge  = (data_i.hue_rem >= data_i.hue_den);
    sat_sub = sat_ge ? (data_i.sat_rem - data_i.sat_den) : data_i.sat_rem;
    hue_sub = hue_ge ? (data_i.hue_rem - data_i.hue_den) : data_i.hue_rem;

    data_d         = data_i;
    data_d.sat_rem = {sat_sub[DIV_W-2:0], 1'b0};
    data_d.hue_rem = {hue_sub[DIV_W-2:0], 1'b0};
    data_d.sat_quo = {data_i.sat_quo[QUO_W-2:0], sat_ge};
    data_d.hue_quo = {data_i.hue_quo[QUO_W-2:0], hue_ge};
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  // Hold the cell valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Advance the partial quotients
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> design/rgb2hsl_back.sv
`timescale 1ns / 1ps
// Output stage: clamps saturation, clears grey pixels, registers the result.
// Depends on rgb2hsl_pkg.
module rgb2hsl_back import rgb2hsl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  div_t data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output hsl_t out_data_o
);

  logic valid_q, valid_d;
  hsl_t data_q, data_d;

  // Saturate a full-scale quotient and force grey to zero
  always_comb begin
    data_d.lightness_sum = data_i.lsum;
    if (data_i.grey) begin
      data_d.hue        = '0;
      data_d.saturation = '0;
    end else begin
      data_d.hue        = data_i.hue_quo[FRAC_W-1:0];
      data_d.saturation = data_i.sat_quo[FRAC_W] ? '1 : data_i.sat_quo[FRAC_W-1:0];
    end
  end

  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  // Hold the result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the finished result
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

>>> design/rgb_to_hsl_converter.sv
`timescale 1ns / 1ps
// RGB to HSL converter. Takes one pixel request per clock unless in_stall_o is
// high and returns hue and saturation as Q0.16 fractions plus the lightness sum
// max+min. It is built from one operand stage, a chain of 17 divider cells that
// each retire one quotient bit of both the saturation and the hue division, and
// one output register. Every stage has its own valid flag, so bubbles close up
// and new pixels keep entering while a finished result waits to be taken.
// Depends on rgb2hsl_pkg, rgb2hsl_front, rgb2hsl_cell and rgb2hsl_back.
module rgb_to_hsl_converter import rgb2hsl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  pix_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output hsl_t out_data_o
);

  logic front_ready;
  logic chain_valid [N_CELLS+1];
  logic chain_ready [N_CELLS+1];
  div_t chain_data  [N_CELLS+1];

  // Operand stage
  rgb2hsl_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (front_ready),
    .data_i  (in_data_i),
    .valid_o (chain_valid[0]),
    .ready_i (chain_ready[0]),
    .data_o  (chain_data[0])
  );

  assign in_stall_o = !front_ready;

  // Divider chain, one quotient bit per cell
  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    rgb2hsl_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[i]),
      .ready_o (chain_ready[i]),
      .data_i  (chain_data[i]),
      .valid_o (chain_valid[i+1]),
      .ready_i (chain_ready[i+1]),
      .data_o  (chain_data[i+1])
    );
  end

  // Result register
  rgb2hsl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (chain_valid[N_CELLS]),
    .ready_o     (chain_ready[N_CELLS]),
    .data_i      (chain_data[N_CELLS]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> design/rgb2hsl_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the RGB to HSL converter, bound to the top level.
// Depends on rgb2hsl_pkg and rgb_to_hsl_converter.
module rgb2hsl_checker import rgb2hsl_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input hsl_t out_data_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // Lightness sum never exceeds twice full scale
  a_lsum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.lightness_sum <= TWO_FS)
    else $error("lightness sum out of range");

  // Zero saturation only for grey, which also has zero hue
  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturation == '0 |-> out_data_o.hue == '0)
    else $error("grey pixel with non-zero hue");

  // An empty output register never holds back new requests
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind rgb_to_hsl_converter rgb2hsl_checker u_rgb2hsl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
